[rtl/core/chslba_pkg.sv]
// chslba_pkg: shared types, constants and helpers for the chs/lba translator core
// used by chslba_prep, chslba_cell, chslba_outq and disk_chs_lba_translator_core
`timescale 1ns / 1ps

package chslba_pkg;

    // width of the logical block address inside the core
    localparam int LBA_BITS = 32;

    localparam int CYL_W    = 10;
    localparam int HEAD_W   = 8;
    localparam int SEC_W    = 6;
    localparam int HPC_W    = 9;
    localparam int PACK_W   = 16;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [CYL_W-1:0] MAX_CYL = 10'h3FF;

    typedef logic [LBA_BITS-1:0] t_lba;

    typedef enum logic [1:0] {
        OP_L2C    = 2'd0,
        OP_C2L    = 2'd1,
        OP_PACKED = 2'd2,
        OP_BAD    = 2'd3
    } t_op;

    // register index as decoded from paddr
    localparam logic REG_SPT = 1'b0;
    localparam logic REG_HPC = 1'b1;

    typedef struct packed {
        logic [SEC_W-1:0] s;
        logic [HPC_W-1:0] h;
        logic             err;
    } t_geom;

    typedef struct packed {
        logic              valid;
        t_op               op;
        logic              err;
        t_lba              lba;
        t_lba              lsh;
        logic [CYL_W-1:0]  cyl;
        logic [HEAD_W-1:0] head;
        logic [SEC_W-1:0]  sec;
        logic [SEC_W-1:0]  rem1;
        logic [HEAD_W-1:0] rem2;
        logic              ovf;
    } t_cell;

    typedef struct packed {
        logic [31:0]       lba;
        logic [CYL_W-1:0]  cyl;
        logic [HEAD_W-1:0] head;
        logic [SEC_W-1:0]  sec;
        logic [PACK_W-1:0] packed_w;
        logic              err;
    } t_res;

    function automatic logic [PACK_W-1:0] pack_word(input logic [CYL_W-1:0] cyl,
                                                    input logic [SEC_W-1:0] sec);
        return {cyl[7:0], cyl[9:8], sec};
    endfunction

endpackage

[rtl/core/chslba_prep.sv]
// chslba_prep: two front stages, operand unpack, range checks and the chs to lba product
// depends on chslba_pkg
`timescale 1ns / 1ps

module chslba_prep
    import chslba_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  t_geom             i_geom,
    input  logic              i_valid,
    input  t_op               i_op,
    input  logic [31:0]       i_lba,
    input  logic [CYL_W-1:0]  i_cyl,
    input  logic [HEAD_W-1:0] i_head,
    input  logic [SEC_W-1:0]  i_sec,
    input  logic [PACK_W-1:0] i_packed,
    output t_cell             o_cell
);

    typedef struct packed {
        logic              valid;
        t_op               op;
        logic              err;
        t_lba              lba;
        logic [CYL_W-1:0]  cyl;
        logic [HEAD_W-1:0] head;
        logic [SEC_W-1:0]  sec;
        logic [17:0]       p1;
    } t_prep;

    t_prep r_a, n_a;
    t_cell r_b, n_b;

    logic [CYL_W-1:0] w_cyl;
    logic [SEC_W-1:0] w_sec;
    logic [18:0]      w_prod;
    logic [23:0]      w_mul;
    logic             w_bad;

    always_comb begin
        w_cyl = '0;
        w_sec = '0;
        case (i_op)
            OP_C2L: begin
                w_cyl = i_cyl;
                w_sec = i_sec;
            end
            OP_PACKED: begin
                w_cyl = {i_packed[7:6], i_packed[15:8]};
                w_sec = i_packed[5:0];
            end
            default: begin
                w_cyl = '0;
                w_sec = '0;
            end
        endcase
        w_bad = (w_sec == '0) || (w_sec > i_geom.s) || ({1'b0, i_head} >= i_geom.h);
        w_prod = 19'(w_cyl) * 19'(i_geom.h);

        n_a.valid = i_valid;
        n_a.op    = i_op;
        n_a.lba   = t_lba'(i_lba);
        n_a.cyl   = w_cyl;
        n_a.head  = i_head;
        n_a.sec   = w_sec;
        n_a.p1    = 18'(w_prod + 19'(i_head));
        case (i_op)
            OP_L2C:            n_a.err = i_geom.err;
            OP_C2L, OP_PACKED: n_a.err = i_geom.err | w_bad;
            default:           n_a.err = 1'b1;
        endcase
    end

    always_comb begin
        w_mul = 24'(r_a.p1) * 24'(i_geom.s);
        n_b       = '0;
        n_b.valid = r_a.valid;
        n_b.op    = r_a.op;
        n_b.err   = r_a.err;
        n_b.lsh   = r_a.lba;
        n_b.cyl   = r_a.cyl;
        n_b.head  = r_a.head;
        n_b.sec   = r_a.sec;
        if (r_a.op == OP_L2C) begin
            n_b.lba = r_a.lba;
        end else begin
            n_b.lba = t_lba'(w_mul) + t_lba'(r_a.sec) - t_lba'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
            r_b.valid <= 1'b0;
        end else if (i_en) begin
            r_a <= n_a;
            r_b <= n_b;
        end
    end

    assign o_cell = r_b;

endmodule

[rtl/core/chslba_cell.sv]
// chslba_cell: one restoring step of both chained divisions, lba by sectors then by heads
// depends on chslba_pkg
`timescale 1ns / 1ps

module chslba_cell
    import chslba_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_geom i_geom,
    input  t_cell i_cell,
    output t_cell o_cell
);

    t_cell r_cell, n_cell;

    logic [SEC_W:0]  w_t1;
    logic            w_ge1;
    logic [HEAD_W:0] w_t2;
    logic            w_ge2;

    always_comb begin
        w_t1  = {i_cell.rem1, i_cell.lsh[LBA_BITS-1]};
        w_ge1 = w_t1 >= {1'b0, i_geom.s};
        w_t2  = {i_cell.rem2, w_ge1};
        w_ge2 = w_t2 >= i_geom.h;

        n_cell      = i_cell;
        n_cell.lsh  = {i_cell.lsh[LBA_BITS-2:0], 1'b0};
        n_cell.rem1 = w_ge1 ? SEC_W'(w_t1 - {1'b0, i_geom.s}) : w_t1[SEC_W-1:0];
        n_cell.rem2 = w_ge2 ? HEAD_W'(w_t2 - i_geom.h) : w_t2[HEAD_W-1:0];
        if (i_cell.op == OP_L2C) begin
            n_cell.cyl = {i_cell.cyl[CYL_W-2:0], w_ge2};
            n_cell.ovf = i_cell.ovf | i_cell.cyl[CYL_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

[rtl/core/chslba_outq.sv]
// chslba_outq: two-entry output buffer, lets the cell chain run while a result beat waits
// depends on chslba_pkg
`timescale 1ns / 1ps

module chslba_outq
    import chslba_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_res i_res,
    input  logic i_m_tready,
    output logic o_space,
    output logic o_valid,
    output t_res o_res
);

    t_res       r_mem [0:1];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       w_pop;

    assign o_valid = r_cnt != 2'd0;
    assign w_pop   = o_valid & i_m_tready;
    assign o_space = (r_cnt != 2'd2) | i_m_tready;
    assign o_res   = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp ^ i_push;
        n_rp  = r_rp ^ w_pop;
        n_cnt = 2'(r_cnt + {1'b0, i_push} - {1'b0, w_pop});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_res;
        end
    end

endmodule

[rtl/core/disk_chs_lba_translator_core.sv]
// disk_chs_lba_translator_core: top level, config registers, cell chain and result formatting
// depends on chslba_pkg, chslba_prep, chslba_cell, chslba_outq
`timescale 1ns / 1ps

// Takes one beat per clock while the output side takes beats and returns one result beat per
// input beat, in order. The path is two front stages, then a chain of LBA_BITS cells each
// producing one quotient bit of lba / sectors and feeding it straight into the heads
// division, then the output buffer. Chain length sets the latency; the throughput is one
// beat per cycle while the output side takes beats. Geometry must only be written while no
// beat is in flight.

module disk_chs_lba_translator_core
    import chslba_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    // lba_in[31:0], cylinder_in[41:32], head_in[49:42], sector_in[55:50], packed_in[71:56]
    input  logic [71:0]        i_s_tdata,
    // op[1:0]
    input  logic [1:0]         i_s_tuser,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    // lba_out[31:0], cylinder_out[41:32], head_out[49:42], sector_out[55:50],
    // packed_out[71:56]
    output logic [71:0]        o_m_tdata,
    // range_error[0]
    output logic               o_m_tuser,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [SEC_W-1:0] r_spt;
    logic [HPC_W-1:0] r_hpc;
    t_geom            w_geom;
    logic             w_en;
    t_cell            w_chain [0:LBA_BITS];
    t_cell            w_last;
    t_res             w_res;
    t_res             w_out;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HPC) ? PDATA_W'(r_hpc) : PDATA_W'(r_spt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spt <= 6'd63;
            r_hpc <= 9'd255;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                REG_SPT: r_spt <= pwdata[SEC_W-1:0];
                REG_HPC: r_hpc <= pwdata[HPC_W-1:0];
                default: r_spt <= r_spt;
            endcase
        end
    end

    // effective geometry
    always_comb begin
        w_geom.s   = (r_spt == '0) ? SEC_W'(1) : r_spt;
        w_geom.h   = (r_hpc == '0) ? HPC_W'(1) : (r_hpc > 9'd256) ? 9'd256 : r_hpc;
        w_geom.err = (r_spt == '0) || (r_hpc == '0) || (r_hpc > 9'd256);
    end

    assign o_s_tready = w_en;

    chslba_prep u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_geom   (w_geom),
        .i_valid  (i_s_tvalid & w_en),
        .i_op     (t_op'(i_s_tuser)),
        .i_lba    (i_s_tdata[31:0]),
        .i_cyl    (i_s_tdata[41:32]),
        .i_head   (i_s_tdata[49:42]),
        .i_sec    (i_s_tdata[55:50]),
        .i_packed (i_s_tdata[71:56]),
        .o_cell   (w_chain[0])
    );

    for (genvar g = 0; g < LBA_BITS; g++) begin : g_cell
        chslba_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_geom  (w_geom),
            .i_cell  (w_chain[g]),
            .o_cell  (w_chain[g+1])
        );
    end

    assign w_last = w_chain[LBA_BITS];

    // result formatting
    always_comb begin
        w_res = '0;
        case (w_last.op)
            OP_L2C: begin
                w_res.lba  = 32'(w_last.lba);
                w_res.cyl  = w_last.ovf ? MAX_CYL : w_last.cyl;
                w_res.head = w_last.rem2;
                w_res.sec  = SEC_W'(w_last.rem1 + SEC_W'(1));
                w_res.err  = w_last.err | w_last.ovf;
            end
            OP_C2L, OP_PACKED: begin
                w_res.lba  = 32'(w_last.lba);
                w_res.cyl  = w_last.cyl;
                w_res.head = w_last.head;
                w_res.sec  = w_last.sec;
                w_res.err  = w_last.err;
            end
            default: begin
                w_res.err  = 1'b1;
            end
        endcase
        w_res.packed_w = (w_last.op == OP_BAD) ? '0 : pack_word(w_res.cyl, w_res.sec);
    end

    chslba_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_en & w_last.valid),
        .i_res      (w_res),
        .i_m_tready (i_m_tready),
        .o_space    (w_en),
        .o_valid    (o_m_tvalid),
        .o_res      (w_out)
    );

    assign o_m_tdata = {w_out.packed_w, w_out.sec, w_out.head, w_out.cyl, w_out.lba};
    assign o_m_tuser = w_out.err;

    a_packed_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[71:56] == pack_word(o_m_tdata[41:32], o_m_tdata[55:50]))
        else $error("packed word does not match cylinder and sector");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output buffer");

    a_no_beat_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("result beat right after reset");

endmodule
